[rtl/aptp_pkg.sv]
// ----------------------------------------------------------------------------
// aptp_pkg: shared definitions for the aging priority task picker
// Table sizing, entry layout, item codes and the priority clamp function.
// ----------------------------------------------------------------------------
`default_nettype none

package aptp_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int COUNT_BITS  = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TAG_W       = 8;
  localparam int PRIO_W      = 16;
  localparam int STATUS_W    = 3;

  typedef logic signed [COUNT_BITS-1:0] count_t;
  typedef logic [TAG_W-1:0]             tag_t;
  typedef logic [STATUS_W-1:0]          status_t;

  typedef struct packed {
    tag_t   tag;
    count_t count;
  } entry_t;

  localparam logic    KIND_INSERT   = 1'b0;
  localparam logic    KIND_DISPATCH = 1'b1;

  localparam status_t ST_INSERTED   = 3'd0;
  localparam status_t ST_IGNORED    = 3'd1;
  localparam status_t ST_DROPPED    = 3'd2;
  localparam status_t ST_DISPATCHED = 3'd3;
  localparam status_t ST_EMPTY      = 3'd4;

  localparam count_t COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  // Clamp a 16-bit signed priority into the signed counter range.
  function automatic count_t sat_prio(input logic signed [PRIO_W-1:0] p);
    logic signed [32:0] e;
    logic signed [32:0] cmax;
    logic signed [32:0] cmin;
    e    = {{(33-PRIO_W){p[PRIO_W-1]}}, p};
    cmax = (33'sd1 <<< (COUNT_BITS - 1)) - 33'sd1;
    cmin = -(33'sd1 <<< (COUNT_BITS - 1));
    if (e > cmax) begin
      e = cmax;
    end else if (e < cmin) begin
      e = cmin;
    end
    return e[COUNT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/aptp_if.sv]
// ----------------------------------------------------------------------------
// aptp_if: stream interfaces of the aging priority task picker
// Task item channel and result item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface aptp_task_if
  import aptp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic                     has_work;
  tag_t                     task_tag;
  logic signed [PRIO_W-1:0] start_priority;

  modport source (output valid, kind, has_work, task_tag, start_priority, input ready);
  modport sink   (input valid, kind, has_work, task_tag, start_priority, output ready);
endinterface

interface aptp_result_if
  import aptp_pkg::*;
();
  logic    valid;
  logic    ready;
  status_t status;
  tag_t    picked_tag;

  modport source (output valid, status, picked_tag, input ready);
  modport sink   (input valid, status, picked_tag, output ready);
endinterface

`default_nettype wire

[rtl/aging_priority_task_picker_core.sv]
// ----------------------------------------------------------------------------
// aging_priority_task_picker_core: pending task table with aging dispatch
// Entries sit in one RAM in arrival order; dispatch ages, scans and compacts.
// ----------------------------------------------------------------------------
// Sequence: insert / ignore / drop / empty go to S_DONE, which loads the result register
//   once it is free. Dispatch, n entries, winner at b: S_SCAN reads, ages and writes back
//   all n entries, S_MOVE shifts entries b + 1 to n - 1 one row toward the head, then S_DONE
//   loads the result register. Flow: one item at a time; tasks.ready is high only in S_IDLE,
//   so a new item waits until the last is through, and S_DONE may wait on results.ready.
// Reset: synchronous; clears fill count and control state, not the RAM (only rows < count read).
`default_nettype none

module aging_priority_task_picker_core
  import aptp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  aptp_task_if.sink      tasks,
  aptp_result_if.source  results
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

  entry_t mem [TABLE_DEPTH];
  entry_t rdata;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] ptr;
  logic             proc;
  logic [IDX_W-1:0] addr_d;
  count_t           best_cnt;
  logic [IDX_W-1:0] best_idx;
  tag_t             best_tag;
  status_t          res_status;
  tag_t             res_tag;
  logic             out_valid;
  status_t          out_status;
  tag_t             out_tag;

  logic             accept;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  count_t           aged;
  logic             best_take;
  logic [IDX_W-1:0] best_idx_next;
  logic             ins_ok;

  assign tasks.ready        = (state == S_IDLE);
  assign accept             = tasks.valid && tasks.ready;
  assign results.valid      = out_valid;
  assign results.status     = out_status;
  assign results.picked_tag = out_tag;

  assign ins_ok = (tasks.kind == KIND_INSERT) && tasks.has_work && (cnt != FULL);

  always_comb begin
    aged          = (rdata.count == COUNT_MIN) ? rdata.count : rdata.count - count_t'(1);
    best_take     = proc && ((addr_d == '0) || (aged < best_cnt));
    best_idx_next = best_take ? addr_d : best_idx;
    rd_en         = 1'b0;
    rd_addr       = ptr[IDX_W-1:0];
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && ins_ok) begin
          we          = 1'b1;
          waddr       = cnt[IDX_W-1:0];
          wdata.tag   = tasks.task_tag;
          wdata.count = sat_prio(tasks.start_priority);
        end
      end
      S_SCAN: begin
        rd_en = (ptr != cnt);
        if (proc) begin
          // write back the aged counter
          we          = 1'b1;
          waddr       = addr_d;
          wdata.tag   = rdata.tag;
          wdata.count = aged;
        end
      end
      S_MOVE: begin
        rd_en = (ptr != cnt);
        if (proc) begin
          // shift one position toward the head
          we    = 1'b1;
          waddr = addr_d - IDX_W'(1);
          wdata = rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    addr_d <= rd_addr;
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ptr       <= '0;
      proc      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      proc <= rd_en;
      if (state == S_DONE && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_tag <= '0;
            if (tasks.kind == KIND_DISPATCH) begin
              if (cnt == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                ptr   <= '0;
                state <= S_SCAN;
              end
            end else begin
              state <= S_DONE;
              if (!tasks.has_work) begin
                res_status <= ST_IGNORED;
              end else if (cnt == FULL) begin
                res_status <= ST_DROPPED;
              end else begin
                res_status <= ST_INSERTED;
                cnt        <= cnt + CNT_W'(1);
              end
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (best_take) begin
            best_cnt <= aged;
            best_idx <= addr_d;
            best_tag <= rdata.tag;
          end
          // last write-back lands this edge; compaction reads start next cycle
          if (ptr == cnt) begin
            ptr   <= CNT_W'(best_idx_next) + CNT_W'(1);
            state <= S_MOVE;
          end
        end
        S_MOVE: begin
          if (rd_en) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (!rd_en && !proc) begin
            cnt        <= cnt - CNT_W'(1);
            res_status <= ST_DISPATCHED;
            res_tag    <= best_tag;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || results.ready) begin
            out_status <= res_status;
            out_tag    <= res_tag;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= FULL)
    else $error("fill count above table depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_MOVE) |-> ptr <= cnt)
    else $error("table pointer past fill count");

  a_disp_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE && !rd_en && !proc) |=> cnt == $past(cnt) - CNT_W'(1))
    else $error("dispatch did not remove one entry");

  a_ins_inc: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && accept && ins_ok) |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("insert did not add one entry");

endmodule

`default_nettype wire

[tb/tb_aging_priority_task_picker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aging_priority_task_picker_core: self-checking bench for the task picker
// Drives insert and dispatch items through the task channel and tracks the
// pending task table alongside the block. Each dispatch ages every tracked
// counter before picking the lowest one, with the earliest arrival winning
// ties. Every result is compared with the oldest outstanding prediction.
// Directed fill/drain first, then random traffic in four phases that vary source idling and sink stalls.
// ----------------------------------------------------------------------------

module tb_aging_priority_task_picker_core;
  import aptp_pkg::*;

  localparam int RANDOM_PER_PHASE = 482;
  localparam int BATCH_LEN        = 40;
  localparam int MAX_GAP          = 30;
  localparam int DRAIN_CYCLES     = 40;
  localparam int STALL_LIMIT      = 4000;

  // Tracks the pending task table in arrival order plus outstanding results.
  class pending_task_tracker;
    tag_t    pend_tag[$];
    longint  pend_count[$];
    status_t want_status[$];
    tag_t    want_tag[$];
    int      errors = 0;

    function int outstanding();
      return want_status.size();
    endfunction

    function void note_accepted_item(logic kind, logic has_work, tag_t tag,
                                     logic signed [PRIO_W-1:0] prio);
      longint  lo;
      longint  hi;
      longint  p;
      int      best;
      status_t st;
      tag_t    picked;
      lo     = -(longint'(1) << (COUNT_BITS - 1));
      hi     = (longint'(1) << (COUNT_BITS - 1)) - 1;
      picked = '0;
      if (kind == KIND_INSERT) begin
        if (!has_work) begin
          st = ST_IGNORED;
        end else if (pend_tag.size() >= TABLE_DEPTH) begin
          st = ST_DROPPED;
        end else begin
          p = prio;
          if (p < lo) p = lo;
          if (p > hi) p = hi;
          pend_tag   = {pend_tag, tag};
          pend_count = {pend_count, p};
          st = ST_INSERTED;
        end
      end else if (pend_tag.size() == 0) begin
        st = ST_EMPTY;
      end else begin
        // age all, then strict less-than keeps the earliest arrival on ties
        best = 0;
        foreach (pend_count[i]) begin
          if (pend_count[i] > lo) pend_count[i]--;
          if (pend_count[i] < pend_count[best]) best = i;
        end
        picked = pend_tag[best];
        pend_tag.delete(best);
        pend_count.delete(best);
        st = ST_DISPATCHED;
      end
      want_status = {want_status, st};
      want_tag    = {want_tag, picked};
    endfunction

    function void check_picker_result(status_t st, tag_t tag);
      status_t exp_st;
      tag_t    exp_tag;
      if (want_status.size() == 0) begin
        $error("unexpected result: status %0d picked_tag 0x%02h", st, tag);
        errors++;
        return;
      end
      exp_st  = want_status.pop_front();
      exp_tag = want_tag.pop_front();
      if (st !== exp_st) begin
        $error("status: expected %0d, actual %0d", exp_st, st);
        errors++;
      end
      if (tag !== exp_tag) begin
        $error("picked_tag: expected 0x%02h, actual 0x%02h", exp_tag, tag);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct  = 0;
  int   sink_stall_pct = 0;
  int   idle_cycles   = 0;

  pending_task_tracker tracker = new;

  aptp_task_if   task_ch();
  aptp_result_if result_ch();

  aging_priority_task_picker_core u_top (
    .clk     (clk),
    .rst     (rst),
    .tasks   (task_ch),
    .results (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one item, with a random lead-in gap, and hold it until the transfer.
  task automatic send_item(logic kind, logic has_work, tag_t tag,
                           logic signed [PRIO_W-1:0] prio);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      task_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    task_ch.valid          <= 1'b1;
    task_ch.kind           <= kind;
    task_ch.has_work       <= has_work;
    task_ch.task_tag       <= tag;
    task_ch.start_priority <= prio;
    do @(posedge clk); while (!task_ch.ready);
    tracker.note_accepted_item(kind, has_work, tag, prio);
  endtask

  function automatic logic signed [PRIO_W-1:0] pick_priority();
    logic signed [PRIO_W-1:0] p;
    case ($urandom_range(3))
      0: p = PRIO_W'($urandom);
      1: p = PRIO_W'(int'($urandom_range(8)) - 4);
      2: p = PRIO_W'(int'($urandom_range(128)) - 64);
      default: begin
        case ($urandom_range(3))
          0: p = 16'sh8000;
          1: p = 16'sh8001;
          2: p = 16'sh7fff;
          default: p = 16'sh7ffe;
        endcase
      end
    endcase
    return p;
  endfunction

  // drop valid so the last transfer is not offered again, then wait
  task automatic wait_until_drained();
    task_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // receiver back-pressure
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.check_picker_result(result_ch.status, result_ch.picked_tag);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (task_ch.valid && task_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("aging_priority_task_picker_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int   fill_prio[16] = '{-32767, 32767, -32768, 0, -1, 1, 5, 5, 5, 100, -100,
                            32766, -32768, 7, 7, 0};
    int   insert_pct;
    logic kind;
    logic has_work;

    rst                    <= 1'b1;
    task_ch.valid          <= 1'b0;
    task_ch.kind           <= KIND_INSERT;
    task_ch.has_work       <= 1'b0;
    task_ch.task_tag       <= '0;
    task_ch.start_priority <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty dispatches, ignored insert, fill to full, drop, drain a few
    send_item(KIND_DISPATCH, 1'b0, 8'h00, 16'sh0000);
    send_item(KIND_DISPATCH, 1'b1, 8'hff, 16'sh7fff);
    send_item(KIND_INSERT, 1'b0, 8'hff, 16'sh8000);
    // first entry ages onto the minimum and ties with a later one already there
    for (int i = 0; i < 16; i++)
      send_item(KIND_INSERT, 1'b1, 8'(i * 17), 16'(fill_prio[i]));
    send_item(KIND_INSERT, 1'b1, 8'haa, 16'sh0000);
    send_item(KIND_INSERT, 1'b0, 8'h55, 16'sh7fff);
    repeat (4) send_item(KIND_DISPATCH, 1'b0, 8'h00, 16'sh0000);

    for (int ph = 0; ph < 4; ph++) begin
      // sender holds off until every outstanding result is back
      wait_until_drained();
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
        default: begin src_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      insert_pct = 50;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % BATCH_LEN == 0) begin
          case ($urandom_range(3))
            0: insert_pct = 25;
            1: insert_pct = 50;
            2: insert_pct = 70;
            default: insert_pct = 90;
          endcase
        end
        kind     = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_DISPATCH;
        has_work = (kind == KIND_DISPATCH) ? 1'($urandom) : ($urandom_range(99) < 88);
        send_item(kind, has_work, tag_t'($urandom), pick_priority());
      end
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("aging_priority_task_picker_core: match");
    end else begin
      $display("aging_priority_task_picker_core: mismatch");
    end
    $finish;
  end

endmodule
